// ===== hdl/cursor_overlay_blend_assert.svh =====
// assertion macros shared by the cursor overlay rtl
// no dependencies; compiled out when SYNTH is defined
`ifndef CURSOR_OVERLAY_BLEND_ASSERT_SVH
`define CURSOR_OVERLAY_BLEND_ASSERT_SVH

`ifndef SYNTH
`define COB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define COB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define COB_ASSERT(lbl, clk, rst, prop, msg)
`define COB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/cob_pkg.sv =====
// shared types and constants of the cursor overlay blend
// no dependencies
package cob_pkg;

   localparam int CURSOR_SIDE = 64;
   localparam int STORE_DEPTH = CURSOR_SIDE * CURSOR_SIDE;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int SIDE_W      = $clog2(CURSOR_SIDE);

   // request tdata layout, lowest field first
   localparam int ADDR_LSB    = 0;
   localparam int WORD_LSB    = 12;
   localparam int COL_LSB     = 44;
   localparam int ROW_LSB     = 57;
   localparam int PIXIN_LSB   = 70;
   localparam int REQ_DATA_W  = 104;
   localparam int RSP_DATA_W  = 32;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOUR  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE  = 3'd5;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;
   localparam int Q_CW    = 3;

   typedef struct packed {
      logic [13:0] left;
      logic [13:0] top;
      logic [6:0]  width;
      logic [6:0]  height;
      logic        colour;
      logic        enable;
   } cob_cfg_type;

   typedef struct packed {
      logic                kind;
      logic                load_ok;
      logic                hit;
      logic                colour;
      logic [STORE_AW-1:0] addr;
      logic [31:0]         data;
   } cob_item_type;

   typedef enum logic [1:0] {
      MODE_PASS,
      MODE_INVERT,
      MODE_REPLACE,
      MODE_BLEND
   } cob_mode_type;

endpackage

// ===== hdl/cursor_overlay_blend.sv =====
// cursor_overlay_blend: draws a hardware cursor over a BGRA pixel stream.
// Requests (req_) carry either a cursor image word (req_tuser low) to be
// written into the cursor store, or a frame pixel with its column and row
// (req_tuser high). Every pixel request gives exactly one response (rsp_)
// holding the composited pixel; image writes give none. Order is kept.
// The csr_ port writes the cursor position, size, mode and enable; write it
// only while no request is in flight.
// Throughput: one request per clock while responses are taken. A pixel's
// result passes through the front register, the queue, the store read
// register and the channel multiplier register, with the divide and
// select feeding the response register that drives rsp_tdata.
// When a response waits with rsp_tready low the back pipeline and the store
// read hold; the four-entry queue and the front register keep taking requests
// until full, and req_tready then drops.
// Reset is synchronous: it empties the pipeline and queue and loads the
// registers with position 0,0, size 32 by 32, colour mode, overlay off.
// The cursor store is not cleared; load every word the cursor uses first.
// depends on cob_pkg, cob_front, cob_queue, cob_back
module cursor_overlay_blend (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // image_addr[11:0], image_word[43:12], pixel_col[56:44], pixel_row[69:57],
   // pixel_in[101:70], zero pad
   input  logic [cob_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pixel_out
   output logic [cob_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [cob_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cob_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cob_pkg::*;

   cob_cfg_type  cfg_ff;
   cob_cfg_type  cfg_in;
   logic         front_valid;
   logic         front_ready;
   cob_item_type front_item;
   logic         q_valid;
   logic         q_pop;
   cob_item_type q_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEFT:   cfg_in.left   = csr_wdata;
            CSR_TOP:    cfg_in.top    = csr_wdata;
            CSR_WIDTH:  cfg_in.width  = csr_wdata[6:0];
            CSR_HEIGHT: cfg_in.height = csr_wdata[6:0];
            CSR_COLOUR: cfg_in.colour = csr_wdata[0];
            CSR_ENABLE: cfg_in.enable = csr_wdata[0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left   <= '0;
         cfg_ff.top    <= '0;
         cfg_ff.width  <= 7'd32;
         cfg_ff.height <= 7'd32;
         cfg_ff.colour <= 1'b1;
         cfg_ff.enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cob_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .in_user   (req_tuser),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   cob_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   cob_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_pop    (q_pop),
      .in_item   (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (rsp_tdata)
   );

endmodule

// ===== hdl/cob_front.sv =====
// front part: takes requests, tests the cursor rectangle, forms the store address
// depends on cob_pkg and cursor_overlay_blend_assert.svh
`include "cursor_overlay_blend_assert.svh"

module cob_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [cob_pkg::REQ_DATA_W-1:0] in_data,
   input  logic                           in_user,
   input  cob_pkg::cob_cfg_type           cfg,
   output logic                           out_valid,
   input  logic                           out_ready,
   output cob_pkg::cob_item_type          out_item
);
   import cob_pkg::*;

   logic               front_valid_ff;
   logic               front_valid_in;
   cob_item_type       item_ff;
   cob_item_type       item_in;
   logic [11:0]        image_addr;
   logic [31:0]        image_word;
   logic [12:0]        pixel_col;
   logic [12:0]        pixel_row;
   logic [31:0]        pixel_in;
   logic [14:0]        dx;
   logic [14:0]        dy;
   logic               inside_x;
   logic               inside_y;
   logic [STORE_AW-1:0] idx;
   logic               take;

   assign image_addr = in_data[ADDR_LSB +: 12];
   assign image_word = in_data[WORD_LSB +: 32];
   assign pixel_col  = in_data[COL_LSB +: 13];
   assign pixel_row  = in_data[ROW_LSB +: 13];
   assign pixel_in   = in_data[PIXIN_LSB +: 32];

   assign in_ready = !front_valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      dx = {2'b00, pixel_col} - {cfg.left[13], cfg.left};
      dy = {2'b00, pixel_row} - {cfg.top[13], cfg.top};
      inside_x = !dx[14] && (dx[13:0] < 14'(cfg.width)) && (dx[13:0] < 14'(CURSOR_SIDE));
      inside_y = !dy[14] && (dy[13:0] < 14'(cfg.height)) && (dy[13:0] < 14'(CURSOR_SIDE));
      idx = STORE_AW'(dy[SIDE_W-1:0]) * STORE_AW'(CURSOR_SIDE) + STORE_AW'(dx[SIDE_W-1:0]);
      item_in.kind    = in_user;
      item_in.colour  = cfg.colour;
      item_in.load_ok = (32'(image_addr) < 32'(STORE_DEPTH));
      if (in_user == CMD_LOAD) begin
         item_in.hit  = 1'b0;
         item_in.addr = STORE_AW'(image_addr);
         item_in.data = image_word;
      end else begin
         item_in.hit  = cfg.enable && inside_x && inside_y;
         item_in.addr = idx;
         item_in.data = pixel_in;
      end
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      if (take) begin
         front_valid_in = 1'b1;
      end else if (out_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = front_valid_ff;
   assign out_item  = item_ff;

   `COB_ASSERT(a_front_inside_pixel, clock, reset,
               front_valid_ff && item_ff.hit |-> item_ff.kind == CMD_PIXEL,
               "load item marked inside cursor")

endmodule

// ===== hdl/cob_queue.sv =====
// short queue between the front and back parts
// depends on cob_pkg and cursor_overlay_blend_assert.svh
`include "cursor_overlay_blend_assert.svh"

module cob_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  cob_pkg::cob_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop,
   output cob_pkg::cob_item_type pop_item
);
   import cob_pkg::*;

   cob_item_type    entries [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff;
   logic [Q_AW-1:0] wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff;
   logic [Q_AW-1:0] rd_ptr_in;
   logic [Q_CW-1:0] count_ff;
   logic [Q_CW-1:0] count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != Q_CW'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_item;
      end
   end

   `COB_ASSERT(a_queue_bound, clock, reset, count_ff <= Q_CW'(Q_DEPTH), "queue count beyond depth")
   `COB_ASSERT_ALWAYS(a_queue_reset, clock, $past(reset) |-> count_ff == '0, "queue not empty after reset")

endmodule

// ===== hdl/cob_back.sv =====
// back part: cursor image store, blend datapath and result register
// depends on cob_pkg and cursor_overlay_blend_assert.svh
`include "cursor_overlay_blend_assert.svh"

module cob_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_pop,
   input  cob_pkg::cob_item_type          in_item,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [cob_pkg::RSP_DATA_W-1:0] out_pixel
);
   import cob_pkg::*;

   logic [31:0]  image_mem [STORE_DEPTH];
   logic         adv;
   logic         pop;
   logic         mem_we;
   logic         mem_re;

   logic         a_valid_ff;
   logic         a_inside_ff;
   logic         a_colour_ff;
   logic [31:0]  a_px_ff;
   logic [31:0]  a_word_ff;

   logic         b_valid_ff;
   cob_mode_type b_mode_ff;
   cob_mode_type b_mode_in;
   logic [31:0]  b_px_ff;
   logic [23:0]  b_word_ff;
   logic [15:0]  b_sum_ff [3];
   logic [15:0]  b_sum_in [3];

   logic         out_valid_ff;
   logic [31:0]  out_pixel_ff;
   logic [31:0]  out_pixel_in;
   logic [7:0]   alpha;

   assign adv    = !out_valid_ff || out_ready;
   assign pop    = in_valid && adv;
   assign in_pop = pop;
   assign mem_we = pop && in_item.kind == CMD_LOAD && in_item.load_ok;
   assign mem_re = pop && in_item.kind == CMD_PIXEL;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         image_mem[in_item.addr] <= in_item.data;
      end
      if (mem_re) begin
         a_word_ff <= image_mem[in_item.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         a_inside_ff <= in_item.hit;
         a_colour_ff <= in_item.colour;
         a_px_ff     <= in_item.data;
      end
   end

   assign alpha = a_word_ff[31:24];

   always_comb begin
      b_mode_in = MODE_PASS;
      if (a_inside_ff) begin
         if (!a_colour_ff) begin
            b_mode_in = (a_word_ff[7:0] == 8'h00) ? MODE_INVERT : MODE_PASS;
         end else if (alpha == 8'hFF) begin
            b_mode_in = MODE_REPLACE;
         end else if (alpha != 8'h00) begin
            b_mode_in = MODE_BLEND;
         end
      end
      for (int c = 0; c < 3; c++) begin
         b_sum_in[c] = 16'(a_word_ff[8*c +: 8]) * 16'(alpha)
                     + 16'(a_px_ff[8*c +: 8]) * 16'(8'hFF - alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_mode_ff <= b_mode_in;
         b_px_ff   <= a_px_ff;
         b_word_ff <= a_word_ff[23:0];
         for (int c = 0; c < 3; c++) begin
            b_sum_ff[c] <= b_sum_in[c];
         end
      end
   end

   // divide by 255 as (x + 1 + (x >> 8)) >> 8, exact below 65535
   always_comb begin
      logic [16:0] q;
      q = '0;
      out_pixel_in = b_px_ff;
      unique case (b_mode_ff)
         MODE_PASS: begin
            out_pixel_in = b_px_ff;
         end
         MODE_INVERT: begin
            out_pixel_in = b_px_ff ^ 32'h00FF_FFFF;
         end
         MODE_REPLACE: begin
            out_pixel_in = {8'hFF, b_word_ff};
         end
         MODE_BLEND: begin
            for (int c = 0; c < 3; c++) begin
               q = 17'(b_sum_ff[c]) + 17'd1 + 17'(b_sum_ff[c][15:8]);
               out_pixel_in[8*c +: 8] = q[15:8];
            end
         end
         default: begin
            out_pixel_in = b_px_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= mem_re;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_pixel_ff <= out_pixel_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;

   `COB_ASSERT(a_back_load_silent, clock, reset,
               pop && in_item.kind == CMD_LOAD |=> !a_valid_ff,
               "load item entered result path")
   `COB_ASSERT(a_back_blend_range, clock, reset,
               b_valid_ff && b_mode_ff == MODE_BLEND |-> b_sum_ff[0] <= 16'd65025
                  && b_sum_ff[1] <= 16'd65025 && b_sum_ff[2] <= 16'd65025,
               "blend sum out of range")

endmodule
